### hdl/tmps_pkg.sv
// Shared types and constants for the triangle maximum path sum block.
// No dependencies.
package tmps_pkg;

  localparam int VALUE_W = 16;
  localparam int SUM_W   = 24;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_PARTIAL  = 2'd1,
    STATUS_TOO_MANY = 2'd2
  } status_t;

  // One item as handed from the index tracker to the update stage.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               skip;      // row beyond the store: no sum, no write
    logic               use_here;  // the entry directly above exists
    logic               col_zero;
    status_t            status;    // meaningful on a last item only
  } item_t;

endpackage

### hdl/tmps_row_mem.sv
// Row store of best path sums: one write port, one registered read port.
// A read of the entry written in the same cycle returns the new data.
module tmps_row_mem
  import tmps_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [SUM_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [SUM_W-1:0] rdata
);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/tmps_index.sv
// Row and column tracking at item accept; classifies each item.
// Depends on tmps_pkg.
module tmps_index
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int AW       = 8,
  parameter int RW       = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [VALUE_W-1:0] value,
  input  logic               last,
  output item_t              item,
  output logic [AW-1:0]      col
);

  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          ovf_r, ovf_nxt;
  logic          skip;
  logic          ended;
  logic          use_here;

  assign skip     = (row_r == RW'(MAX_ROWS));
  assign use_here = (RW'(col_r) < row_r);
  assign ended    = !skip && !use_here;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ovf_nxt = ovf_r;
    if (acc) begin
      if (skip) begin
        ovf_nxt = 1'b1;
      end else if (ended) begin
        row_nxt = row_r + 1'b1;
        col_nxt = '0;
      end else begin
        col_nxt = col_r + 1'b1;
      end
      // last item: start over for the next triangle
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_comb begin
    item.value    = value;
    item.last     = last;
    item.skip     = skip;
    item.use_here = !skip && use_here;
    item.col_zero = (col_r == '0);
    if (ovf_r || skip) begin
      item.status = STATUS_TOO_MANY;
    end else if (!ended) begin
      item.status = STATUS_PARTIAL;
    end else begin
      item.status = STATUS_OK;
    end
  end

  assign col = col_r;

endmodule

### hdl/tmps_update.sv
// Add-max stage: combines the read sum with the left neighbor, writes the store
// back, tracks the row maximum and holds the result register. Depends on tmps_pkg.
module tmps_update
  import tmps_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  item_t            item_in,
  input  logic [AW-1:0]    col_in,
  input  logic [SUM_W-1:0] rdata,
  output logic             we,
  output logic [AW-1:0]    waddr,
  output logic [SUM_W-1:0] wdata,
  output logic             adv,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SUM_W-1:0] out_best_sum,
  output logic [1:0]       out_status
);

  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r;
  logic [AW-1:0]    s1_col_r;
  logic [SUM_W-1:0] left_r, left_nxt;
  logic [SUM_W-1:0] best_r, best_nxt;
  logic             ov_r, ov_nxt;
  logic [SUM_W-1:0] ob_r, ob_nxt;
  status_t          os_r, os_nxt;
  logic [SUM_W-1:0] here;
  logic [SUM_W-1:0] above;
  logic [SUM_W:0]   raw;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] best_upd;
  logic             fire;

  // hold a last item while the result register is still occupied
  assign adv  = !(s1_valid_r && s1_item_r.last && ov_r && out_stall);
  assign fire = s1_valid_r && adv;

  always_comb begin
    here = s1_item_r.use_here ? rdata : '0;
    above = here;
    if (!s1_item_r.col_zero && (left_r > here)) begin
      above = left_r;
    end
    raw = {1'b0, above} + {{(SUM_W-VALUE_W+1){1'b0}}, s1_item_r.value};
    sum = raw[SUM_W] ? SUM_MAX : raw[SUM_W-1:0];
    best_upd = best_r;
    if (!s1_item_r.skip && (s1_item_r.col_zero || (sum > best_r))) begin
      best_upd = sum;
    end
  end

  assign we    = fire && !s1_item_r.skip;
  assign waddr = s1_col_r;
  assign wdata = sum;

  always_comb begin
    s1_valid_nxt = acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    left_nxt = left_r;
    best_nxt = best_r;
    ov_nxt   = ov_r && out_stall;
    ob_nxt   = ob_r;
    os_nxt   = os_r;
    if (fire) begin
      if (!s1_item_r.skip) begin
        left_nxt = here;
      end
      best_nxt = best_upd;
      if (s1_item_r.last) begin
        ov_nxt   = 1'b1;
        ob_nxt   = best_upd;
        os_nxt   = s1_item_r.status;
        left_nxt = '0;
        best_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      left_r     <= '0;
      best_r     <= '0;
      ov_r       <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      left_r     <= left_nxt;
      best_r     <= best_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= item_in;
      s1_col_r  <= col_in;
    end
    ob_r <= ob_nxt;
    os_r <= os_nxt;
  end

  assign out_valid    = ov_r;
  assign out_best_sum = ob_r;
  assign out_status   = os_r;

endmodule

### hdl/triangle_max_path_sum.sv
// Triangle maximum path sum: one element per item, one result per triangle.
// Throughput: one item per cycle while in_stall is low, set by the single read and write of the row store.
// Result path: a last item's store read happens at the accept edge, then add-max writes
// the result register that drives out_valid; a stalled, occupied result register holds it.
// Reset: synchronous active-low rst_n clears counters, row maximum and valid flags;
// the row store is not cleared and needs no clearing pass.
module triangle_max_path_sum
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SUM_W-1:0]    out_best_sum,
  output logic [1:0]          out_status
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 1);

  logic             acc;
  logic             adv;
  item_t            item;
  logic [AW-1:0]    col;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [SUM_W-1:0] wdata;
  logic [SUM_W-1:0] rdata;

  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  tmps_index #(
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW),
    .RW       (RW)
  ) u_index (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .value (in_value),
    .last  (in_last),
    .item  (item),
    .col   (col)
  );

  tmps_row_mem #(
    .DEPTH (MAX_ROWS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (acc),
    .raddr (col),
    .rdata (rdata)
  );

  tmps_update #(
    .AW (AW)
  ) u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .item_in      (item),
    .col_in       (col),
    .rdata        (rdata),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_best_sum (out_best_sum),
    .out_status   (out_status)
  );

endmodule

### verif/tb_triangle_max_path_sum.sv
// Testbench for triangle_max_path_sum: random and directed triangles, checked
// against a cycle-free path-sum predictor held in a small scoreboard class.
// Depends on hdl/tmps_pkg.sv and hdl/triangle_max_path_sum.sv.
`timescale 1ns / 100ps

module tb_triangle_max_path_sum;
  import tmps_pkg::*;

  localparam int ROWS_KEPT      = 256;
  localparam int IDLE_LIMIT     = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 8;
  localparam int PRINT_CAP      = 40;

  typedef struct {
    logic [SUM_W-1:0] best;
    status_t          status;
  } peak_t;

  class best_sum_tracker;
    logic [SUM_W-1:0] upper_row [ROWS_KEPT];
    logic [SUM_W-1:0] diag_carry;
    logic [SUM_W-1:0] row_peak;
    int unsigned      next_col;
    int unsigned      cur_row;
    bit               spilled;
    peak_t            peaks_due [$];
    int unsigned      mismatches;

    function void clear_triangle();
      diag_carry = '0;
      row_peak   = '0;
      next_col   = 0;
      cur_row    = 0;
      spilled    = 1'b0;
    endfunction

    function int unsigned pending();
      return peaks_due.size();
    endfunction

    task flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t MISMATCH %s", $realtime, what);
    endtask

    // Advance the path-sum state by one accepted element.
    function void take_element(input logic [VALUE_W-1:0] value, input logic last);
      logic [SUM_W-1:0] above;
      logic [SUM_W-1:0] old_here;
      logic [SUM_W:0]   total;
      bit               ended;
      peak_t            p;
      ended = 1'b0;
      if (cur_row >= ROWS_KEPT) begin
        spilled = 1'b1;
      end else begin
        above    = '0;
        old_here = '0;
        if (next_col < cur_row) begin
          old_here = upper_row[next_col];
          above    = old_here;
        end
        if (next_col > 0 && diag_carry > above)
          above = diag_carry;
        total = {{(SUM_W + 1 - VALUE_W){1'b0}}, value} + {1'b0, above};
        if (total > {1'b0, SUM_MAX})
          total = {1'b0, SUM_MAX};
        upper_row[next_col] = total[SUM_W-1:0];
        diag_carry = old_here;
        if (next_col == 0 || total[SUM_W-1:0] > row_peak)
          row_peak = total[SUM_W-1:0];
        if (next_col >= cur_row) begin
          ended    = 1'b1;
          cur_row  = cur_row + 1;
          next_col = 0;
        end else begin
          next_col = next_col + 1;
        end
      end
      if (last) begin
        p.best = row_peak;
        if (spilled)
          p.status = STATUS_TOO_MANY;
        else if (!ended)
          p.status = STATUS_PARTIAL;
        else
          p.status = STATUS_OK;
        peaks_due.push_back(p);
        clear_triangle();
      end
    endfunction

    task match_result(input logic [SUM_W-1:0] best, input logic [1:0] status);
      peak_t p;
      if (peaks_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result best_sum=%0d status=%0d", best, status));
      end else begin
        p = peaks_due.pop_front();
        if (best !== p.best)
          flag_mismatch($sformatf("best_sum got %0d want %0d", best, p.best));
        if (status !== p.status)
          flag_mismatch($sformatf("status got %0d want %0d", status, p.status));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                in_last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SUM_W-1:0]    out_best_sum;
  logic [1:0]          out_status;

  best_sum_tracker board;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  logic            hold_off = 1'b0;
  int unsigned     elements_sent = 0;
  int unsigned     quiet_cycles = 0;

  triangle_max_path_sum #(.MAX_ROWS(ROWS_KEPT)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_best_sum (out_best_sum),
    .out_status   (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check on accept, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_result(out_best_sum, out_status);
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
      $display("triangle_max_path_sum verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_element(input logic [VALUE_W-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_last  <= last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    board.take_element(value, last);
    elements_sent++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(input bit all_max);
    int unsigned roll;
    if (all_max)
      return '1;
    roll = $urandom_range(99);
    if (roll < 10)
      return '0;
    else if (roll < 25)
      return '1;
    else if (roll < 40)
      return VALUE_W'($urandom_range(15));
    else
      return VALUE_W'($urandom);
  endfunction

  // Send rows 0..rows-1; when cut short, the last row stops partway.
  task automatic send_triangle(input int unsigned rows, input bit cut_short,
                               input bit all_max);
    int unsigned keep;
    int unsigned width;
    keep = rows;
    if (cut_short && rows > 1)
      keep = $urandom_range(rows - 1, 1);
    for (int unsigned r = 0; r < rows; r++) begin
      width = (r == rows - 1) ? keep : r + 1;
      for (int unsigned c = 0; c < width; c++)
        send_element(pick_value(all_max), (r == rows - 1) && (c == width - 1));
    end
  endtask

  task automatic send_random_triangles(input int unsigned count);
    int unsigned stop_at;
    int unsigned rows;
    stop_at = elements_sent + count;
    while (elements_sent < stop_at) begin
      rows = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      send_triangle(rows, $urandom_range(4) == 0, 1'b0);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
  endtask

  initial begin
    board = new();
    board.clear_triangle();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 53;
    // single-element triangles at both value extremes
    send_element('0, 1'b1);
    send_element('1, 1'b1);
    send_element(16'd1, 1'b0);
    send_element(16'd2, 1'b0);
    send_element(16'd3, 1'b0);
    send_element(16'd4, 1'b0);
    send_element(16'd5, 1'b0);
    send_element(16'd6, 1'b1);
    // last arrives inside an unfinished row
    send_element(16'd10, 1'b0);
    send_element(16'd20, 1'b0);
    send_element(16'd30, 1'b0);
    send_element(16'd5, 1'b1);
    send_triangle(4, 1'b0, 1'b1);
    send_element(16'd7, 1'b0);
    send_element(16'd8, 1'b1);

    send_random_triangles(170);
    wait_results_drained();

    send_idle_pct = 53;
    recv_idle_pct = 12;
    send_random_triangles(170);

    // hold the result side off long enough for the block to back up
    send_idle_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < 60; i++)
      send_element(pick_value(1'b0), 1'b1);

    recv_idle_pct = 0;
    send_random_triangles(150);
    // one deep triangle at the largest values
    send_triangle(24, 1'b0, 1'b1);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.flag_mismatch($sformatf("%0d results never arrived", board.pending()));
    if (board.mismatches == 0)
      $display("triangle_max_path_sum verification clean");
    else
      $display("triangle_max_path_sum verification failed");
    $finish;
  end

endmodule

### files.f
hdl/tmps_pkg.sv
hdl/tmps_row_mem.sv
hdl/tmps_index.sv
hdl/tmps_update.sv
hdl/triangle_max_path_sum.sv
verif/tb_triangle_max_path_sum.sv
